### rtl/gbia_pkg.sv
// gbia_pkg: shared types and constants for the grouped bitmap inode allocator.
// No dependencies; every other file but gbia_seg_eval uses it.
package gbia_pkg;

    localparam int CNT_W     = 13;   // counts, config values, inode numbers
    localparam int MODE_W    = 2;
    localparam int SLOT_W    = 7;
    localparam int LOAD_W    = 32;
    localparam int STAT_W    = 2;
    localparam int CFG_IDX_W = 2;

    // request modes
    localparam logic [MODE_W-1:0] MODE_LOAD_WORD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_GROUP = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOAD_TOTAL = 2'd2;
    localparam logic [MODE_W-1:0] MODE_ALLOC      = 2'd3;

    // result status codes
    localparam logic [STAT_W-1:0] ST_LOAD_DONE = 2'd0;
    localparam logic [STAT_W-1:0] ST_ALLOCATED = 2'd1;
    localparam logic [STAT_W-1:0] ST_NONE_FREE = 2'd2;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INODES_PER_GROUP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_INODES     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FREE       = 2'd2;

    // config reset values
    localparam logic [CNT_W-1:0] RST_INODES_PER_GROUP = 13'd256;
    localparam logic [CNT_W-1:0] RST_TOTAL_INODES     = 13'd4096;
    localparam logic [CNT_W-1:0] RST_FIRST_FREE       = 13'd11;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INIT,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

### rtl/gbia_if.sv
// gbia channel interfaces: request, result and config write channels.
// Depends on gbia_pkg for field widths.
interface gbia_in_if;
    logic                         valid;
    logic                         ready;
    logic [gbia_pkg::MODE_W-1:0]  mode;
    logic [gbia_pkg::SLOT_W-1:0]  slot;
    logic [gbia_pkg::LOAD_W-1:0]  load_value;

    modport source (output valid, output mode, output slot, output load_value, input ready);
    modport sink   (input valid, input mode, input slot, input load_value, output ready);
endinterface

interface gbia_out_if;
    logic                         valid;
    logic                         ready;
    logic [gbia_pkg::STAT_W-1:0]  status;
    logic [gbia_pkg::CNT_W-1:0]   inode_number;

    modport source (output valid, output status, output inode_number, input ready);
    modport sink   (input valid, input status, input inode_number, output ready);
endinterface

interface gbia_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [gbia_pkg::CFG_IDX_W-1:0]  index;
    logic [gbia_pkg::CNT_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/grouped_bitmap_inode_allocator_core.sv
// Grouped bitmap inode allocator, top level: usage map and group count memories,
// scan sequencer and result register. Depends on gbia_pkg, gbia_if, gbia_seg_eval.
//
// Software loads every usage map word (mode 0), every group free count (mode 1)
// and the total free count (mode 2) before the first allocate (mode 3); each
// load item returns one "load done" result the cycle after it is taken.
// An allocate walks the inodes in order, one segment per cycle, where a segment
// is the part of one map word that lies in one group. It reads the map word and
// the group count from their registered-read memories, picks the lowest clear
// bit at or above first_free_inode in a group with a nonzero count, sets it and
// decrements both counts. An allocate passes an init state, the scan and a done
// state before its result enters the result register, where it may then wait
// on o_out.ready. A scan covers at most NUM_WORDS + MAX_GROUPS - 1 segments;
// if the total free count is zero, the init state skips the scan.
// If the total free count is zero, or no eligible bit exists, the result is
// "none free" with inode 0 and nothing changes. One item is in work at a time;
// a new item is taken only while idle and once the result register is empty or
// being read in the same cycle.
// Config writes are taken any time but must only be issued while idle.
module grouped_bitmap_inode_allocator_core #(
    parameter int MAX_INODES = 4096,
    parameter int MAX_GROUPS = 16,
    parameter int WORD_BITS  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gbia_cfg_if.sink    i_cfg,
    gbia_in_if.sink     i_in,
    gbia_out_if.source  o_out
);
    import gbia_pkg::*;

    localparam int NUM_WORDS = (MAX_INODES + WORD_BITS - 1) / WORD_BITS;
    localparam int WIW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;   // word address
    localparam int GIW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1; // group address
    localparam int IW  = $clog2(MAX_INODES + 1);                    // inode cursor
    localparam int BW  = $clog2(WORD_BITS + 1);                     // bit bound
    localparam int XBW = $clog2(WORD_BITS);                         // bit index
    localparam int XW  = CNT_W + IW + $clog2(MAX_GROUPS + 1);       // scratch math

    // ---------------- config registers ----------------
    logic [CNT_W-1:0] r_cfg_ipg, r_cfg_total, r_cfg_first;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_ipg   <= RST_INODES_PER_GROUP;
            r_cfg_total <= RST_TOTAL_INODES;
            r_cfg_first <= RST_FIRST_FREE;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_INODES_PER_GROUP: r_cfg_ipg   <= i_cfg.data;
                CFG_TOTAL_INODES:     r_cfg_total <= i_cfg.data;
                CFG_FIRST_FREE:       r_cfg_first <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // ---------------- state memories ----------------
    logic [WORD_BITS-1:0] mem_map [NUM_WORDS];
    logic [CNT_W-1:0]     mem_gfc [MAX_GROUPS];
    logic [WORD_BITS-1:0] r_map_q;
    logic [CNT_W-1:0]     r_gfc_q;

    logic                 map_we, gfc_we;
    logic [WIW-1:0]       map_wa;
    logic [GIW-1:0]       gfc_wa;
    logic [WORD_BITS-1:0] map_wd;
    logic [CNT_W-1:0]     gfc_wd;

    // ---------------- control and scan registers ----------------
    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_total, n_total;          // total free count
    logic [IW-1:0]     r_idx, n_idx;              // next inode index to scan
    logic [IW-1:0]     r_wbase, n_wbase;          // first index of current word
    logic [WIW-1:0]    r_w, n_w;                  // current word address
    logic [GIW-1:0]    r_g, n_g;                  // current group
    logic [IW-1:0]     r_ge, n_ge;                // end of current group (clipped)
    logic [IW-1:0]     r_lim, n_lim;              // scan limit
    logic              r_pv, n_pv;                // a segment read is in flight
    logic [IW-1:0]     r_s_wbase, n_s_wbase;      // segment in flight
    logic [WIW-1:0]    r_s_w, n_s_w;
    logic [GIW-1:0]    r_s_g, n_s_g;
    logic [BW-1:0]     r_s_lo, n_s_lo;
    logic [BW-1:0]     r_s_hi, n_s_hi;
    logic [STAT_W-1:0] r_res_status, n_res_status; // pending result
    logic [CNT_W-1:0]  r_res_ino, n_res_ino;
    logic              r_out_valid, n_out_valid;   // result register
    logic [STAT_W-1:0] r_out_status, n_out_status;
    logic [CNT_W-1:0]  r_out_ino, n_out_ino;

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            mem_map[map_wa] <= map_wd;
        end
        r_map_q <= mem_map[r_w];
    end

    always_ff @(posedge i_clk) begin
        if (gfc_we) begin
            mem_gfc[gfc_wa] <= gfc_wd;
        end
        r_gfc_q <= mem_gfc[r_g];
    end

    // ---------------- scan limits from config ----------------
    logic [XW-1:0] ipg_c, tot_c, span, lim_c, ge_step;
    logic [IW-1:0] ge_init;

    always_comb begin
        ipg_c = (r_cfg_ipg == '0) ? XW'(1) : XW'(r_cfg_ipg);
        tot_c = (XW'(r_cfg_total) > XW'(MAX_INODES)) ? XW'(MAX_INODES) : XW'(r_cfg_total);
        // groups at or beyond MAX_GROUPS are never reached
        span  = XW'(MAX_GROUPS) * ipg_c;
        lim_c = (span < tot_c) ? span : tot_c;
        ge_init = (ipg_c < lim_c) ? IW'(ipg_c) : IW'(lim_c);
        ge_step = XW'(r_ge) + ipg_c;
        if (ge_step > XW'(r_lim)) begin
            ge_step = XW'(r_lim);
        end
    end

    // ---------------- segment issue: bounds of the next segment ----------------
    logic          issue;
    logic [XW-1:0] wend, seg_end, ffm1, thr;
    logic [BW-1:0] thr_c, lo_raw, lo_eff, hi_raw;

    always_comb begin
        issue   = (r_idx < r_lim);
        wend    = XW'(r_wbase) + XW'(WORD_BITS);
        seg_end = (wend < XW'(r_ge)) ? wend : XW'(r_ge);
        // bits below first_free_inode - 1 (as an index) are reserved
        ffm1    = (r_cfg_first == '0) ? '0 : XW'(r_cfg_first) - XW'(1);
        thr     = (ffm1 > XW'(r_wbase)) ? ffm1 - XW'(r_wbase) : '0;
        thr_c   = (thr > XW'(WORD_BITS)) ? BW'(WORD_BITS) : BW'(thr);
        lo_raw  = BW'(XW'(r_idx) - XW'(r_wbase));
        lo_eff  = (thr_c > lo_raw) ? thr_c : lo_raw;
        hi_raw  = BW'(seg_end - XW'(r_wbase));
    end

    // ---------------- segment evaluate ----------------
    logic           seg_hit;
    logic [XBW-1:0] seg_bit;

    gbia_seg_eval #(
        .WORD_BITS (WORD_BITS)
    ) u_seg_eval (
        .i_word     (r_map_q),
        .i_lo       (r_s_lo),
        .i_hi       (r_s_hi),
        .i_grp_open (r_gfc_q != '0),
        .o_hit      (seg_hit),
        .o_bit      (seg_bit)
    );

    // ---------------- handshakes ----------------
    logic out_free, in_acc;

    assign out_free   = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && out_free;
    assign in_acc     = i_in.valid && i_in.ready;

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_out_status;
    assign o_out.inode_number = r_out_ino;

    // ---------------- next state and datapath ----------------
    always_comb begin
        n_state      = r_state;
        n_total      = r_total;
        n_idx        = r_idx;
        n_wbase      = r_wbase;
        n_w          = r_w;
        n_g          = r_g;
        n_ge         = r_ge;
        n_lim        = r_lim;
        n_pv         = 1'b0;
        n_s_wbase    = r_s_wbase;
        n_s_w        = r_s_w;
        n_s_g        = r_s_g;
        n_s_lo       = r_s_lo;
        n_s_hi       = r_s_hi;
        n_res_status = r_res_status;
        n_res_ino    = r_res_ino;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_status = r_out_status;
        n_out_ino    = r_out_ino;
        map_we       = 1'b0;
        map_wa       = r_s_w;
        map_wd       = r_map_q | (WORD_BITS'(1) << seg_bit);
        gfc_we       = 1'b0;
        gfc_wa       = r_s_g;
        gfc_wd       = r_gfc_q - CNT_W'(1);

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in.mode == MODE_ALLOC) begin
                        n_state = S_INIT;
                    end else begin
                        // loads finish at once; out-of-range slots are dropped
                        if (i_in.mode == MODE_LOAD_WORD && 32'(i_in.slot) < NUM_WORDS) begin
                            map_we = 1'b1;
                            map_wa = WIW'(i_in.slot);
                            map_wd = WORD_BITS'(i_in.load_value);
                        end
                        if (i_in.mode == MODE_LOAD_GROUP && 32'(i_in.slot) < MAX_GROUPS) begin
                            gfc_we = 1'b1;
                            gfc_wa = GIW'(i_in.slot);
                            gfc_wd = CNT_W'(i_in.load_value);
                        end
                        if (i_in.mode == MODE_LOAD_TOTAL) begin
                            n_total = CNT_W'(i_in.load_value);
                        end
                        n_out_valid  = 1'b1;
                        n_out_status = ST_LOAD_DONE;
                        n_out_ino    = '0;
                    end
                end
            end

            S_INIT: begin
                n_lim   = IW'(lim_c);
                n_idx   = '0;
                n_wbase = '0;
                n_w     = '0;
                n_g     = '0;
                n_ge    = ge_init;
                if (r_total == '0) begin
                    n_res_status = ST_NONE_FREE;
                    n_res_ino    = '0;
                    n_state      = S_DONE;
                end else begin
                    n_state = S_SCAN;
                end
            end

            S_SCAN: begin
                // issue: read word and group of the next segment, advance cursor
                if (issue) begin
                    n_pv      = 1'b1;
                    n_s_wbase = r_wbase;
                    n_s_w     = r_w;
                    n_s_g     = r_g;
                    n_s_lo    = lo_eff;
                    n_s_hi    = hi_raw;
                    n_idx     = IW'(seg_end);
                    if (seg_end == wend) begin
                        n_w     = r_w + WIW'(1);
                        n_wbase = IW'(wend);
                    end
                    if (seg_end == XW'(r_ge)) begin
                        n_g  = r_g + GIW'(1);
                        n_ge = IW'(ge_step);
                    end
                end
                // evaluate: data of the segment issued last cycle is here now
                if (r_pv && seg_hit) begin
                    map_we       = 1'b1;
                    gfc_we       = 1'b1;
                    n_total      = r_total - CNT_W'(1);
                    n_res_status = ST_ALLOCATED;
                    n_res_ino    = CNT_W'(XW'(r_s_wbase) + XW'(seg_bit) + XW'(1));
                    n_pv         = 1'b0;
                    n_state      = S_DONE;
                end else if (!r_pv && !issue) begin
                    n_res_status = ST_NONE_FREE;
                    n_res_ino    = '0;
                    n_state      = S_DONE;
                end
            end

            S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_ino    = r_res_ino;
                    n_state      = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_total     <= '0;
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_pv        <= n_pv;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_wbase      <= n_wbase;
        r_w          <= n_w;
        r_g          <= n_g;
        r_ge         <= n_ge;
        r_lim        <= n_lim;
        r_s_wbase    <= n_s_wbase;
        r_s_w        <= n_s_w;
        r_s_g        <= n_s_g;
        r_s_lo       <= n_s_lo;
        r_s_hi       <= n_s_hi;
        r_res_status <= n_res_status;
        r_res_ino    <= n_res_ino;
        r_out_status <= n_out_status;
        r_out_ino    <= n_out_ino;
    end

endmodule

### rtl/gbia_seg_eval.sv
// gbia_seg_eval: finds the lowest free, eligible bit in one scanned word segment.
// Depends on nothing but its parameter; pure combinational logic.
module gbia_seg_eval #(
    parameter int WORD_BITS = 32
) (
    input  logic [WORD_BITS-1:0]                i_word,     // set bit = used
    input  logic [$clog2(WORD_BITS+1)-1:0]      i_lo,       // first bit allowed
    input  logic [$clog2(WORD_BITS+1)-1:0]      i_hi,       // one past last bit
    input  logic                                i_grp_open, // group count nonzero
    output logic                                o_hit,
    output logic [$clog2(WORD_BITS)-1:0]        o_bit
);
    localparam int BW  = $clog2(WORD_BITS + 1);
    localparam int XBW = $clog2(WORD_BITS);

    logic [WORD_BITS-1:0] cand;

    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            cand[b] = i_grp_open && !i_word[b] && (BW'(b) >= i_lo) && (BW'(b) < i_hi);
        end
    end

    // lowest candidate wins
    always_comb begin
        o_bit = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (cand[b]) begin
                o_bit = XBW'(b);
            end
        end
    end

    assign o_hit = |cand;

endmodule

### rtl/gbia_checker.sv
// gbia_checker: port-level checks on the allocator top, attached by bind.
// Depends on gbia_pkg for mode and status codes.
module gbia_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic [gbia_pkg::MODE_W-1:0]  in_mode,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [gbia_pkg::STAT_W-1:0]  out_status,
    input logic [gbia_pkg::CNT_W-1:0]   out_inode
);
    import gbia_pkg::*;

    // a load item answers in the very next cycle
    a_load_answers: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_mode != MODE_ALLOC |=> out_valid)
        else $error("load item gave no result next cycle");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_status == ST_LOAD_DONE || out_status == ST_ALLOCATED
                       || out_status == ST_NONE_FREE))
        else $error("unknown status code");

    a_zero_inode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_status == ST_LOAD_DONE || out_status == ST_NONE_FREE)
        |-> out_inode == '0)
        else $error("inode number set without allocation");

    // an allocate never finishes in the cycle after it is taken
    a_alloc_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_mode == MODE_ALLOC |=> !(out_valid && !$past(out_valid)))
        else $error("allocate answered too early");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_inode))
        else $error("stalled result changed");

endmodule

bind grouped_bitmap_inode_allocator_core gbia_checker u_gbia_checker (
    .clk        (i_clk),
    .rst_n      (i_rst_n),
    .in_valid   (i_in.valid),
    .in_ready   (i_in.ready),
    .in_mode    (i_in.mode),
    .out_valid  (o_out.valid),
    .out_ready  (o_out.ready),
    .out_status (o_out.status),
    .out_inode  (o_out.inode_number)
);

### verif/gbia_alloc_checker.sv
// Checker for the grouped bitmap inode allocator: follows the config, request and result
// channels, keeps its own copy of the usage map and free counts, and compares each result.
// Depends on gbia_pkg and the channel interfaces in gbia_if.
module gbia_alloc_checker #(
    parameter int MAX_INODES = 4096,
    parameter int MAX_GROUPS = 16,
    parameter int WORD_BITS  = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    gbia_cfg_if  i_cfg,
    gbia_in_if   i_in,
    gbia_out_if  i_out,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_allocated,
    output int   o_none_free
);
    timeunit 1ns;
    timeprecision 1ps;

    import gbia_pkg::*;

    localparam int NUM_WORDS = (MAX_INODES + WORD_BITS - 1) / WORD_BITS;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  inode;
    } t_result;

    logic [WORD_BITS-1:0] usage_map  [NUM_WORDS];
    logic [CNT_W-1:0]     group_free [MAX_GROUPS];
    logic [CNT_W-1:0]     total_free;
    logic [CNT_W-1:0]     ipg_reg;
    logic [CNT_W-1:0]     total_reg;
    logic [CNT_W-1:0]     first_free_reg;

    t_result expected_q[$];
    int      fail_count    = 0;
    int      allocated_cnt = 0;
    int      none_free_cnt = 0;

    assign o_fail_count = fail_count;
    assign o_allocated  = allocated_cnt;
    assign o_none_free  = none_free_cnt;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    // First eligible clear bit, group by group; marks it used and returns inode
    // number, or zero when nothing can be handed out.
    function automatic logic [CNT_W-1:0] take_free_inode();
        int unsigned ipg, span, groups, start, count, idx, g, b;
        if (total_free == '0)
            return '0;
        ipg    = (ipg_reg == '0) ? 1 : ipg_reg;
        span   = (total_reg > MAX_INODES) ? MAX_INODES : total_reg;
        groups = (span + ipg - 1) / ipg;
        for (g = 0; g < groups && g < MAX_GROUPS; g++) begin
            start = g * ipg;
            count = (g == groups - 1) ? span - start : ipg;
            if (group_free[g] == '0)
                continue;
            for (b = 0; b < count; b++) begin
                idx = start + b;
                if (usage_map[idx / WORD_BITS][idx % WORD_BITS])
                    continue;
                if (idx + 1 < first_free_reg)
                    continue;
                usage_map[idx / WORD_BITS][idx % WORD_BITS] = 1'b1;
                group_free[g] = group_free[g] - 1'b1;
                total_free    = total_free - 1'b1;
                return CNT_W'(idx + 1);
            end
        end
        return '0;
    endfunction

    function automatic t_result predict_item(input logic [MODE_W-1:0] mode,
                                             input logic [SLOT_W-1:0] slot,
                                             input logic [LOAD_W-1:0] value);
        t_result r;
        r.status = ST_LOAD_DONE;
        r.inode  = '0;
        case (mode)
            MODE_LOAD_WORD:  if (slot < NUM_WORDS) usage_map[slot] = value[WORD_BITS-1:0];
            MODE_LOAD_GROUP: if (slot < MAX_GROUPS) group_free[slot] = value[CNT_W-1:0];
            MODE_LOAD_TOTAL: total_free = value[CNT_W-1:0];
            default: begin
                r.inode  = take_free_inode();
                r.status = (r.inode != '0) ? ST_ALLOCATED : ST_NONE_FREE;
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            ipg_reg        = RST_INODES_PER_GROUP;
            total_reg      = RST_TOTAL_INODES;
            first_free_reg = RST_FIRST_FREE;
            foreach (usage_map[w]) usage_map[w] = '0;
            foreach (group_free[g]) group_free[g] = '0;
            total_free = '0;
            expected_q.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_INODES_PER_GROUP: ipg_reg        = i_cfg.data;
                    CFG_TOTAL_INODES:     total_reg      = i_cfg.data;
                    CFG_FIRST_FREE:       first_free_reg = i_cfg.data;
                    default: ;
                endcase
            end
            // a result is always registered after its item is taken, so pop first
            if (i_out.valid && i_out.ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("result with nothing pending: status %0d inode %0d",
                                              i_out.status, i_out.inode_number));
                end else begin
                    want = expected_q.pop_front();
                    if (i_out.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  i_out.status, want.status));
                    if (i_out.inode_number !== want.inode)
                        report_mismatch($sformatf("inode %0d, expected %0d",
                                                  i_out.inode_number, want.inode));
                    if (want.status == ST_ALLOCATED)
                        allocated_cnt++;
                    else if (want.status == ST_NONE_FREE)
                        none_free_cnt++;
                end
            end
            if (i_in.valid && i_in.ready)
                expected_q.push_back(predict_item(i_in.mode, i_in.slot, i_in.load_value));
        end
        o_pending <= expected_q.size();
    end

endmodule

### verif/tb_grouped_bitmap_inode_allocator_core.sv
// Testbench top for grouped_bitmap_inode_allocator_core: clock, reset, request and
// config stimulus, random result back-pressure and the final verdict.
// Depends on gbia_pkg, gbia_if, the core and gbia_alloc_checker.
module tb_grouped_bitmap_inode_allocator_core;
    timeunit 1ns;
    timeprecision 1ps;

    import gbia_pkg::*;

    localparam int NUM_WORDS   = 128;
    localparam int NUM_GROUPS  = 16;
    localparam int NUM_PHASES  = 10;
    localparam int PHASE_ITEMS = 20;
    localparam int IDLE_PCT    = 35;
    // Slowest legal run: ~600 items, each up to a full map scan plus random
    // stalls on both sides; this limit is several times that.
    localparam int CYCLE_LIMIT = 1_000_000;
    // spare register index: the block must ignore writes to it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;

    logic clk = 1'b0;
    logic rst_n;
    bit   steady_flow = 1'b0;   // when set, neither side idles
    int   cycle_count = 0;
    int   items_sent  = 0;
    int   layouts     = 0;
    int   fail_count;
    int   pending;
    int   allocated;
    int   none_free;

    gbia_in_if  in_ch ();
    gbia_out_if out_ch ();
    gbia_cfg_if cfg_ch ();

    grouped_bitmap_inode_allocator_core u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    gbia_alloc_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg        (cfg_ch),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_allocated  (allocated),
        .o_none_free  (none_free)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side back-pressure: one ready update per edge, held low in reset.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d items still pending", cycle_count, pending);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Map word contents, biased toward full words so scans run deep into the map.
    function automatic logic [LOAD_W-1:0] pick_word();
        case ($urandom_range(9))
            0:       return '0;
            1, 2, 3: return '1;
            4, 5:    return ~(32'h1 << $urandom_range(31));
            6:       return $urandom | $urandom | $urandom;
            default: return $urandom;
        endcase
    endfunction

    // Group free counts: zero often (group skipped), sometimes junk in the upper bits.
    function automatic logic [LOAD_W-1:0] pick_count();
        case ($urandom_range(5))
            0:       return '0;
            1:       return $urandom;
            default: return $urandom_range(1, 40);
        endcase
    endfunction

    function automatic logic [LOAD_W-1:0] pick_total();
        case ($urandom_range(7))
            0:       return '0;
            1:       return $urandom;
            default: return $urandom_range(1, 500);
        endcase
    endfunction

    // One request item. valid is only lowered inside an idle gap, so back-to-back
    // items never see a low and a high in the same time step.
    task automatic send_item(input logic [MODE_W-1:0] mode,
                             input logic [SLOT_W-1:0] slot,
                             input logic [LOAD_W-1:0] value);
        while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.mode       <= mode;
        in_ch.slot       <= slot;
        in_ch.load_value <= value;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        items_sent++;
    endtask

    // Stop sending and wait until every expected result has come back.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Only called with the block drained.
    task automatic apply_layout(input logic [CNT_W-1:0] ipg,
                                input logic [CNT_W-1:0] total,
                                input logic [CNT_W-1:0] first);
        write_reg(CFG_INODES_PER_GROUP, ipg);
        write_reg(CFG_TOTAL_INODES, total);
        write_reg(CFG_FIRST_FREE, first);
        layouts++;
    endtask

    task automatic load_everything();
        for (int w = 0; w < NUM_WORDS; w++)
            send_item(MODE_LOAD_WORD, SLOT_W'(w), pick_word());
        for (int g = 0; g < NUM_GROUPS; g++)
            send_item(MODE_LOAD_GROUP, SLOT_W'(g), pick_count());
        send_item(MODE_LOAD_TOTAL, SLOT_W'($urandom), pick_total());
    endtask

    // Fresh counts and a few rewritten words, then mostly allocations with some
    // stray loads mixed in (group slots past the last group get ignored).
    task automatic run_phase(input int phase);
        for (int g = 0; g < NUM_GROUPS; g++)
            send_item(MODE_LOAD_GROUP, SLOT_W'(g), pick_count());
        send_item(MODE_LOAD_TOTAL, SLOT_W'($urandom), pick_total());
        repeat (6) send_item(MODE_LOAD_WORD, SLOT_W'($urandom_range(127)), pick_word());
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            // hold-off: let the block empty out halfway through some phases
            if (i == PHASE_ITEMS / 2 && phase % 2 == 0)
                drain_results();
            case ($urandom_range(19))
                0:       send_item(MODE_LOAD_WORD, SLOT_W'($urandom_range(127)), pick_word());
                1:       send_item(MODE_LOAD_GROUP, SLOT_W'($urandom_range(127)), pick_count());
                2:       send_item(MODE_LOAD_TOTAL, SLOT_W'($urandom), pick_total());
                default: send_item(MODE_ALLOC, SLOT_W'($urandom), $urandom);
            endcase
        end
    endtask

    initial begin
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.mode       = MODE_LOAD_WORD;
        in_ch.slot       = '0;
        in_ch.load_value = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = CFG_INODES_PER_GROUP;
        cfg_ch.data      = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed part ---
        // total free count resets to zero: answers none free without touching the map
        send_item(MODE_ALLOC, SLOT_W'($urandom), $urandom);
        load_everything();
        // word 0 fully clear: reserved inodes below 11 are passed over
        send_item(MODE_LOAD_WORD, SLOT_W'(0), 32'h0);
        send_item(MODE_LOAD_GROUP, SLOT_W'(0), 32'h1);
        send_item(MODE_LOAD_TOTAL, SLOT_W'(0), 32'hFFFF_E003);   // only low bits count
        send_item(MODE_ALLOC, SLOT_W'($urandom), $urandom);
        // group 0 now at zero, so the scan skips it
        send_item(MODE_ALLOC, SLOT_W'($urandom), $urandom);
        // group slots past the last group are ignored
        send_item(MODE_LOAD_GROUP, SLOT_W'(16), 32'h5);
        send_item(MODE_LOAD_GROUP, SLOT_W'(127), 32'hFFFF_FFFF);
        send_item(MODE_LOAD_TOTAL, SLOT_W'(0), 32'h0);
        send_item(MODE_ALLOC, SLOT_W'($urandom), $urandom);
        send_item(MODE_LOAD_TOTAL, SLOT_W'(0), 32'h0000_1FFF);
        send_item(MODE_LOAD_WORD, SLOT_W'(127), 32'h7FFF_FFFF);  // only the highest inode free
        send_item(MODE_LOAD_GROUP, SLOT_W'(0), 32'hFFFF_FFFF);
        drain_results();
        // one big group, everything below the last inode reserved
        apply_layout(13'd4096, 13'd4096, 13'd4096);
        send_item(MODE_ALLOC, SLOT_W'($urandom), $urandom);
        // counts nonzero but no eligible bit left
        send_item(MODE_ALLOC, SLOT_W'($urandom), $urandom);
        drain_results();
        // zero group size behaves as one inode per group
        apply_layout(13'd0, 13'd4096, 13'd1);
        send_item(MODE_ALLOC, SLOT_W'($urandom), $urandom);
        drain_results();
        // oversized total is clamped to the map size
        apply_layout(13'd8191, 13'd8191, 13'd1);
        send_item(MODE_ALLOC, SLOT_W'($urandom), $urandom);
        drain_results();
        // no inodes at all: no groups to scan
        apply_layout(13'd256, 13'd0, 13'd1);
        send_item(MODE_ALLOC, SLOT_W'($urandom), $urandom);
        drain_results();
        write_reg(CFG_SPARE_INDEX, 13'h1FFF);

        // --- random part ---
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_results();
            case (p)
                0: apply_layout(RST_INODES_PER_GROUP, RST_TOTAL_INODES, RST_FIRST_FREE);
                1: apply_layout(13'd4096, 13'd4096, 13'd1);
                2: apply_layout(13'd1000, 13'd3500, 13'd37);   // groups split map words
                3: apply_layout(13'd1, 13'd4096, 13'd1);
                4: apply_layout(13'd300, 13'd1, 13'd1);
                5: apply_layout(13'd8191, 13'd8191, 13'd8191);
                6: apply_layout(13'd512, 13'd4096, 13'd4097);
                default: apply_layout(CNT_W'($urandom_range(256, 4096)),
                                      CNT_W'($urandom_range(1, 4096)),
                                      CNT_W'($urandom_range(1, 4097)));
            endcase
            // one phase runs with no idling on either side
            steady_flow = (p == 2);
            run_phase(p);
        end
        steady_flow = 1'b0;

        drain_results();
        repeat (20) @(posedge clk);
        $display("Run: %0d request items over %0d layouts, %0d inodes handed out,",
                 items_sent, layouts, allocated);
        $display("     %0d none-free answers, %0d results outstanding.", none_free, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
